/* rtl/cdq_pkg.sv */
// Package for the circular deque: field widths, operation codes, controller
// state encoding and the command bundle from controller to datapath.
// No dependencies.
package cdq_pkg;

   localparam int MODE_W  = 2;
   localparam int FIELD_W = 32;
   localparam int CAP_W   = 11;
   localparam int RSP_W   = 72;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 2'd0,
      MODE_PUSH_BACK  = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_BACK   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   typedef struct packed {
      logic do_op;
      logic rd_en;
   } cmd_type;

endpackage

/* rtl/cdq_ram.sv */
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

/* rtl/cdq_ctrl.sv */
// Controller state machine for the circular deque: accepts a request,
// schedules the ring read and holds the response until it is taken.
// Depends on cdq_pkg.
module cdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cdq_pkg::cmd_type cmd
);
   import cdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign cmd.do_op  = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.rd_en  = (state_ff == ST_FETCH);

endmodule

/* rtl/cdq_datapath.sv */
// Datapath for the circular deque: head and tail pointers, entry count,
// effective capacity and the ring store.
// Depends on cdq_pkg and cdq_ram.
module cdq_datapath #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdq_pkg::cmd_type              cmd,
   input  logic                          csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]     csr_wr_data,
   input  logic [cdq_pkg::MODE_W-1:0]    req_mode,
   input  logic [cdq_pkg::FIELD_W-1:0]   req_data,
   output logic                          rsp_accepted,
   output logic [cdq_pkg::FIELD_W-1:0]   rsp_front,
   output logic [cdq_pkg::FIELD_W-1:0]   rsp_rear,
   output logic                          rsp_empty,
   output logic                          rsp_full
);
   import cdq_pkg::*;

   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int XW        = (CW > CAP_W) ? CW : CAP_W;
   localparam int RESET_CAP = (DEPTH < 1024) ? DEPTH : 1024;

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic          ok_ff, ok_in;

   logic [XW-1:0] cap_wide;
   logic [CW-1:0] head_up, tail_up;
   logic [AW-1:0] head_next_up, tail_next_up, head_next_dn, tail_next_dn;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   logic          full_now;
   mode_type      op;

   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data_a, rd_data_b;
   logic [FIELD_W-1:0]    front_ext, rear_ext;

   // A capacity of zero acts as one; anything above the built depth is clamped.
   always_comb begin
      cap_wide = XW'(csr_wr_data);
      if (cap_wide == '0) begin
         cap_in = CW'(1);
      end else if (cap_wide > XW'(DEPTH)) begin
         cap_in = CW'(DEPTH);
      end else begin
         cap_in = CW'(cap_wide);
      end
   end

   assign head_up      = CW'(head_ff) + CW'(1);
   assign tail_up      = CW'(tail_ff) + CW'(1);
   assign head_next_up = (head_up >= cap_ff) ? '0 : AW'(head_up);
   assign tail_next_up = (tail_up >= cap_ff) ? '0 : AW'(tail_up);
   assign head_next_dn = (head_ff == '0) ? AW'(cap_ff - CW'(1)) : head_ff - AW'(1);
   assign tail_next_dn = (tail_ff == '0) ? AW'(cap_ff - CW'(1)) : tail_ff - AW'(1);

   assign full_now = (count_ff >= cap_ff);
   assign op       = mode_type'(req_mode);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      unique case (op)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (!full_now) begin
               ok_in    = 1'b1;
               wr_en    = cmd.do_op;
               count_in = count_ff + CW'(1);
               if (count_ff == '0) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (op == MODE_PUSH_FRONT) begin
                  head_in = head_next_dn;
                  wr_addr = head_next_dn;
               end else begin
                  tail_in = tail_next_up;
                  wr_addr = tail_next_up;
               end
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK: begin
            if (count_ff != '0) begin
               ok_in    = 1'b1;
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (op == MODE_POP_FRONT) begin
                  head_in = head_next_up;
               end else begin
                  tail_in = tail_next_dn;
               end
            end
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CW'(RESET_CAP);
         ok_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= cap_in;
      end else if (cmd.do_op) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
   end

   // Words are kept at the built width; narrower words are sign-extended back to the field width.
   generate
      if (DATA_WIDTH <= FIELD_W) begin : g_narrow
         assign wr_data   = req_data[DATA_WIDTH-1:0];
         assign front_ext = FIELD_W'(signed'(rd_data_a));
         assign rear_ext  = FIELD_W'(signed'(rd_data_b));
      end else begin : g_wide
         assign wr_data   = {{(DATA_WIDTH-FIELD_W){1'b0}}, req_data};
         assign front_ext = rd_data_a[FIELD_W-1:0];
         assign rear_ext  = rd_data_b[FIELD_W-1:0];
      end
   endgenerate

   cdq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (cmd.rd_en),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_ff),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rsp_accepted = ok_ff;
   assign rsp_empty    = (count_ff == '0);
   assign rsp_full     = full_now;
   assign rsp_front    = rsp_empty ? '1 : front_ext;
   assign rsp_rear     = rsp_empty ? '1 : rear_ext;

endmodule

/* rtl/circular_deque.sv */
// Top level of the circular deque: a bounded double-ended queue in a ring store.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
//   Channel   Direction  Contents
//   req_*     in         tuser: mode; tdata: data_value
//   rsp_*     out        tdata: accepted, front_value, rear_value, is_empty, is_full
//   csr_*     in         capacity write, no read-back
//
// Each request passes through the idle, fetch and send states in turn: the
// pointer update and ring write at acceptance, the registered two-port ring
// read, then the response. A stalled response holds the block in its response
// state and no new request is taken. Reset empties the deque and sets the
// capacity to 1024, clamped to DEPTH; no clearing pass is needed.
module circular_deque #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cdq_pkg::FIELD_W-1:0]    req_tdata,   // [31:0] data_value
   input  logic [cdq_pkg::MODE_W-1:0]     req_tuser,   // [1:0] mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] accepted, [32:1] front_value, [64:33] rear_value, [65] is_empty,
   // [66] is_full, [71:67] zero
   output logic [cdq_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]      csr_wr_data
);
   import cdq_pkg::*;

   cmd_type            cmd;
   logic               accepted;
   logic [FIELD_W-1:0] front_value;
   logic [FIELD_W-1:0] rear_value;
   logic               is_empty;
   logic               is_full;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_mode     (req_tuser),
      .req_data     (req_tdata),
      .rsp_accepted (accepted),
      .rsp_front    (front_value),
      .rsp_rear     (rear_value),
      .rsp_empty    (is_empty),
      .rsp_full     (is_full)
   );

   assign rsp_tdata = {5'b0, is_full, is_empty, rear_value, front_value, accepted};

endmodule

/* verif/circular_deque_tb.sv */
// Self-checking testbench for circular_deque: directed and random push and pop requests under
// several capacities, checked against a behavioral deque kept in a scoreboard.
// Depends on cdq_pkg and the circular_deque RTL.
module circular_deque_tb;
   import cdq_pkg::*;

   localparam int RING_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic                accepted;
      logic [FIELD_W-1:0]  front_value;
      logic [FIELD_W-1:0]  rear_value;
      logic                is_empty;
      logic                is_full;
   } deque_status_type;

   class deque_scoreboard;
      logic [FIELD_W-1:0] ring [RING_DEPTH];
      int unsigned        head;
      int unsigned        tail;
      int unsigned        count;
      logic [CAP_W-1:0]   capacity;
      deque_status_type   pending_q [$];
      int                 errors;

      function new();
         head     = 0;
         tail     = 0;
         count    = 0;
         capacity = 11'd1024;
         errors   = 0;
      endfunction

      // A capacity write empties the deque but leaves the ring contents alone.
      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
         head     = 0;
         tail     = 0;
         count    = 0;
      endfunction

      function int unsigned usable_cap();
         if (capacity == 0) return 1;
         if (capacity > RING_DEPTH) return RING_DEPTH;
         return 32'(capacity);
      endfunction

      function void note_request(mode_type op, logic [FIELD_W-1:0] word);
         int unsigned      cap;
         deque_status_type want;
         cap           = usable_cap();
         want.accepted = 1'b0;
         if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
            if (count < cap) begin
               if (count == 0) begin
                  head = 0;
                  tail = 0;
               end else if (op == MODE_PUSH_FRONT) begin
                  head = (head == 0) ? cap - 1 : head - 1;
               end else begin
                  tail = (tail + 1 >= cap) ? 0 : tail + 1;
               end
               ring[(op == MODE_PUSH_FRONT) ? head : tail] = word;
               count++;
               want.accepted = 1'b1;
            end
         end else if (count != 0) begin
            if (count == 1) begin
               head = 0;
               tail = 0;
            end else if (op == MODE_POP_FRONT) begin
               head = (head + 1 >= cap) ? 0 : head + 1;
            end else begin
               tail = (tail == 0) ? cap - 1 : tail - 1;
            end
            count--;
            want.accepted = 1'b1;
         end
         want.front_value = (count == 0) ? '1 : ring[head];
         want.rear_value  = (count == 0) ? '1 : ring[tail];
         want.is_empty    = (count == 0);
         want.is_full     = (count >= cap);
         pending_q.push_back(want);
      endfunction

      function void compare(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] bits);
         deque_status_type want;
         if (pending_q.size() == 0) begin
            $error("response arrived with no request outstanding: %h", bits);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         compare("accepted", FIELD_W'(want.accepted), FIELD_W'(bits[0]));
         compare("front_value", want.front_value, bits[32:1]);
         compare("rear_value", want.rear_value, bits[64:33]);
         compare("is_empty", FIELD_W'(want.is_empty), FIELD_W'(bits[65]));
         compare("is_full", FIELD_W'(want.is_full), FIELD_W'(bits[66]));
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [FIELD_W-1:0]  req_tdata;    // [31:0] data_value
   logic [MODE_W-1:0]   req_tuser;    // [1:0] mode
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [0] accepted, [32:1] front, [64:33] rear, [65] empty, [66] full
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_wr_en;
   logic [CAP_W-1:0]    csr_wr_data;

   deque_scoreboard sb;
   bit              calm;
   int              sender_gap_pct;

   circular_deque #(
      .DEPTH      (RING_DEPTH),
      .DATA_WIDTH (FIELD_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // Response side stalls in bursts; the stall rate changes every so often so
   // that long stretches with no stalls occur as well.
   initial begin : rsp_throttle
      int stall_left;
      int stall_pct;
      int span;
      rsp_tready = 1'b0;
      stall_left = 0;
      stall_pct  = 20;
      span       = 0;
      forever begin
         @(negedge clock);
         if (span == 0) begin
            stall_pct = 20 * $urandom_range(0, 2);
            span      = 150;
         end else begin
            span--;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if (!calm && $urandom_range(0, 99) < stall_pct)
               stall_left = $urandom_range(1, 12);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   function automatic logic [FIELD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input mode_type op, input logic [FIELD_W-1:0] word);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < sender_gap_pct)
         gap = $urandom_range(1, 12);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = word;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, word);
   endtask

   // Holds off new requests until every outstanding response has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      sb.set_capacity(value);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_ops(input int n);
      int       push_pct;
      mode_type op;
      push_pct       = 50;
      sender_gap_pct = 20 * $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         // Swing the push/pop balance so small rings run into full and empty.
         if (i % 40 == 0)
            push_pct = 20 + 30 * $urandom_range(0, 2);
         if (i == n / 2)
            drain();
         if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
         send_op(op, random_word());
      end
   endtask

   initial begin : stimulus
      logic [CAP_W-1:0] caps [10];
      sb             = new();
      calm           = 1'b0;
      sender_gap_pct = 15;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_PUSH_FRONT;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset capacity: refused pops, front push wrapping below zero, extremes.
      send_op(MODE_POP_FRONT, 32'h1111_1111);
      send_op(MODE_POP_BACK, 32'h2222_2222);
      send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
      send_op(MODE_PUSH_FRONT, 32'h8000_0000);
      send_op(MODE_PUSH_BACK, 32'hffff_ffff);
      send_op(MODE_PUSH_BACK, 32'h0000_0000);
      send_op(MODE_POP_FRONT, 32'h0);
      send_op(MODE_POP_BACK, 32'h0);
      send_op(MODE_POP_BACK, 32'h0);
      send_op(MODE_POP_FRONT, 32'h0);
      send_op(MODE_POP_FRONT, 32'h0);

      // A single-entry ring is full after one push.
      write_capacity(11'd1);
      send_op(MODE_PUSH_BACK, 32'h1234_5678);
      send_op(MODE_PUSH_FRONT, 32'hdead_beef);
      send_op(MODE_PUSH_BACK, 32'hcafe_f00d);
      send_op(MODE_POP_BACK, 32'h0);
      send_op(MODE_PUSH_FRONT, 32'ha5a5_a5a5);
      send_op(MODE_POP_FRONT, 32'h0);

      write_capacity(11'd2);
      send_op(MODE_PUSH_FRONT, 32'h0000_0001);
      send_op(MODE_PUSH_FRONT, 32'h0000_0002);
      send_op(MODE_PUSH_BACK, 32'h0000_0003);
      send_op(MODE_POP_FRONT, 32'h0);
      send_op(MODE_PUSH_BACK, 32'h5a5a_5a5a);
      send_op(MODE_POP_BACK, 32'h0);
      send_op(MODE_POP_BACK, 32'h0);

      // Oversized capacity clamps to the built depth.
      write_capacity(11'd2047);
      sender_gap_pct = 5;
      for (int i = 0; i < 12; i++)
         send_op($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, random_word());
      repeat (4)
         send_op($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK, 32'h0);

      caps = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd2047, 11'd7, 11'd1024, 11'd16,
               CAP_W'($urandom_range(2, 1024)), CAP_W'($urandom_range(1, 64))};
      foreach (caps[k]) begin
         write_capacity(caps[k]);
         if (k == 9)
            calm = 1'b1;
         random_ops(101);
      end

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque.sv
verif/circular_deque_tb.sv
